@@ sv/rcc_pkg.sv @@
// rcc_pkg: widths, types, command and register codes for the rectangle collision checker
// no dependencies; imported by every other file of the block

package rcc_pkg;

  localparam int COORD_W  = 19;
  localparam int EDGE_W   = COORD_W + 1;
  localparam int PROD_W   = COORD_W + EDGE_W;
  localparam int DOT_W    = PROD_W + 1;
  localparam int MAX_OBS  = 256;
  localparam int CNT_W    = $clog2(MAX_OBS + 1);
  localparam int SLOT_W   = $clog2(MAX_OBS);
  localparam int IDX_W    = 9;
  localparam int CFG_IDX_W = 4;
  localparam int N_AXES   = 4;
  localparam int N_CORNER = 4;
  localparam int LANE_STAGES = 4;

  typedef enum logic [1:0] {
    CMD_FOOT  = 2'd0,
    CMD_POINT = 2'd1,
    CMD_END   = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VEH_AX = 4'd0,
    CFG_VEH_AY = 4'd1,
    CFG_VEH_BX = 4'd2,
    CFG_VEH_BY = 4'd3,
    CFG_VEH_CX = 4'd4,
    CFG_VEH_CY = 4'd5,
    CFG_VEH_DX = 4'd6,
    CFG_VEH_DY = 4'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } vec_t;

  typedef struct packed {
    logic [EDGE_W-1:0] x;
    logic [EDGE_W-1:0] y;
  } edge_t;

  typedef vec_t [N_CORNER-1:0] rect_t;

  // one separating-axis lane: axis plus both rectangles
  typedef struct packed {
    edge_t axis;
    rect_t veh;
    rect_t obs;
  } lane_in_t;

  // point-in-vehicle lane: point, vehicle corners and vehicle edges AB and BC
  typedef struct packed {
    vec_t  pt;
    rect_t veh;
    edge_t ab;
    edge_t bc;
  } pt_lane_in_t;

  function automatic edge_t edge_of(vec_t p, vec_t q);
    edge_t e;
    e.x = EDGE_W'($signed(q.x)) - EDGE_W'($signed(p.x));
    e.y = EDGE_W'($signed(q.y)) - EDGE_W'($signed(p.y));
    return e;
  endfunction

  // perpendicular of an edge: (e.y, -e.x)
  function automatic edge_t perp(edge_t e);
    edge_t r;
    r.x = e.y;
    r.y = -e.x;
    return r;
  endfunction

endpackage

@@ sv/rcc_if.sv @@
// rcc_if: valid/ready channel interfaces for input items, results and config writes
// depends on rcc_pkg

interface rcc_in_if;
  import rcc_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic [COORD_W-1:0] x_a;
  logic [COORD_W-1:0] y_a;
  logic [COORD_W-1:0] x_b;
  logic [COORD_W-1:0] y_b;
  logic [COORD_W-1:0] x_c;
  logic [COORD_W-1:0] y_c;
  logic [COORD_W-1:0] x_d;
  logic [COORD_W-1:0] y_d;

  modport source (output valid, cmd, x_a, y_a, x_b, y_b, x_c, y_c, x_d, y_d, input ready);
  modport sink   (input valid, cmd, x_a, y_a, x_b, y_b, x_c, y_c, x_d, y_d, output ready);
endinterface

interface rcc_out_if;
  import rcc_pkg::*;
  logic             valid;
  logic             ready;
  logic             collision;
  logic [IDX_W-1:0] obstacle_index;
  logic             overflow;

  modport source (output valid, collision, obstacle_index, overflow, input ready);
  modport sink   (input valid, collision, obstacle_index, overflow, output ready);
endinterface

interface rcc_cfg_if;
  import rcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COORD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/rcc_axis_lane.sv @@
// rcc_axis_lane: projects both rectangles onto one axis and tests strict interval overlap
// four registered stages: products, dot sums, min/max, overlap; depends on rcc_pkg

module rcc_axis_lane (
  input  logic              clk_i,
  input  logic              adv_i,
  input  rcc_pkg::lane_in_t lane_i,
  output logic              ovl_o
);
  import rcc_pkg::*;

  localparam int NPT = 2 * N_CORNER;

  vec_t                     pt [NPT];
  logic signed [PROD_W-1:0] px_q [NPT];
  logic signed [PROD_W-1:0] py_q [NPT];
  logic signed [DOT_W-1:0]  dot_q [NPT];
  logic signed [DOT_W-1:0]  lo_q [2];
  logic signed [DOT_W-1:0]  hi_q [2];
  logic                     ovl_q;

  function automatic logic signed [DOT_W-1:0] min2(logic signed [DOT_W-1:0] a,
                                                  logic signed [DOT_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [DOT_W-1:0] max2(logic signed [DOT_W-1:0] a,
                                                  logic signed [DOT_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // vehicle corners first, obstacle corners after
  always_comb begin
    for (int k = 0; k < N_CORNER; k++) begin
      pt[k]            = lane_i.veh[k];
      pt[k + N_CORNER] = lane_i.obs[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < NPT; k++) begin
        px_q[k]  <= $signed(pt[k].x) * $signed(lane_i.axis.x);
        py_q[k]  <= $signed(pt[k].y) * $signed(lane_i.axis.y);
        dot_q[k] <= DOT_W'(px_q[k]) + DOT_W'(py_q[k]);
      end
      for (int r = 0; r < 2; r++) begin
        lo_q[r] <= min2(min2(dot_q[4*r], dot_q[4*r+1]), min2(dot_q[4*r+2], dot_q[4*r+3]));
        hi_q[r] <= max2(max2(dot_q[4*r], dot_q[4*r+1]), max2(dot_q[4*r+2], dot_q[4*r+3]));
      end
      ovl_q <= (lo_q[0] < lo_q[1]) ? (lo_q[1] < hi_q[0]) : (lo_q[0] < hi_q[1]);
    end
  end

  assign ovl_o = ovl_q;

endmodule

@@ sv/rcc_point_lane.sv @@
// rcc_point_lane: strict point-inside-vehicle test along vehicle edges AB and BC
// four registered stages matching the axis lanes; depends on rcc_pkg

module rcc_point_lane (
  input  logic                 clk_i,
  input  logic                 adv_i,
  input  rcc_pkg::pt_lane_in_t lane_i,
  output logic                 inside_o
);
  import rcc_pkg::*;

  // dot slots: 0 a.ab, 1 p.ab, 2 b.ab, 3 b.bc, 4 p.bc, 5 c.bc
  localparam int ND = 6;

  vec_t                     src [ND];
  edge_t                    dir [ND];
  logic signed [PROD_W-1:0] px_q [ND];
  logic signed [PROD_W-1:0] py_q [ND];
  logic signed [DOT_W-1:0]  dot_q [ND];
  logic [3:0]               cmp_q;
  logic                     inside_q;

  always_comb begin
    src[0] = lane_i.veh[0];
    src[1] = lane_i.pt;
    src[2] = lane_i.veh[1];
    src[3] = lane_i.veh[1];
    src[4] = lane_i.pt;
    src[5] = lane_i.veh[2];
    for (int k = 0; k < ND; k++) begin
      dir[k] = (k < 3) ? lane_i.ab : lane_i.bc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < ND; k++) begin
        px_q[k]  <= $signed(src[k].x) * $signed(dir[k].x);
        py_q[k]  <= $signed(src[k].y) * $signed(dir[k].y);
        dot_q[k] <= DOT_W'(px_q[k]) + DOT_W'(py_q[k]);
      end
      cmp_q[0] <= dot_q[0] < dot_q[1];
      cmp_q[1] <= dot_q[1] < dot_q[2];
      cmp_q[2] <= dot_q[3] < dot_q[4];
      cmp_q[3] <= dot_q[4] < dot_q[5];
      inside_q <= &cmp_q;
    end
  end

  assign inside_o = inside_q;

endmodule

@@ sv/rect_collision_checker.sv @@
// rect_collision_checker: top level; config registers, input pipeline, lanes, frame state
// depends on rcc_pkg, rcc_if, rcc_axis_lane, rcc_point_lane

// Checks a stream of obstacle footprints and points against the vehicle rectangle held in
// eight config registers. One item is taken every clock unless the pipeline holds. Each
// item runs through six stages (input register, edge/axis register, then the four
// multiply, sum, min/max and compare stages of four separating-axis lanes and one point
// lane in parallel) and is then applied in order to the frame state; an end marker's
// result goes to the output register as it is applied. Items keep flowing while a result
// waits; the pipeline holds only when a second end marker reaches the last stage before
// the previous result has been taken. Config must be written while the pipeline is empty.

module rect_collision_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  rcc_in_if.sink    in_if,
  rcc_out_if.source out_if,
  rcc_cfg_if.sink   cfg_if
);
  import rcc_pkg::*;

  localparam int LAST = LANE_STAGES - 1;

  // config
  rect_t veh_q;

  // pipeline
  logic  vld1_q, vld2_q;
  cmd_e  cmd1_q, cmd2_q;
  rect_t obs1_q, obs2_q;
  edge_t axis2_q [N_AXES];
  edge_t ab2_q, bc2_q;
  logic  vld_q [LANE_STAGES];
  cmd_e  cmd_q [LANE_STAGES];
  logic  adv, commit;

  edge_t veh_ab, veh_bc;
  rect_t obs_in;

  lane_in_t    lane_in [N_AXES];
  logic        lane_ovl [N_AXES];
  pt_lane_in_t pt_in;
  logic        pt_inside;
  logic        all_ovl;

  // frame state
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              cur_q, cur_d;
  logic              hit_q, hit_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              drop_q, drop_d;

  // result register
  logic             out_valid_q, out_valid_d;
  logic             coll_q, coll_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic             ovf_q, ovf_d;
  logic             end_commit;

  // config port
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      veh_q <= '0;
    end else if (cfg_if.valid) begin
      unique case (cfg_reg_e'(cfg_if.index))
        CFG_VEH_AX: veh_q[0].x <= cfg_if.data;
        CFG_VEH_AY: veh_q[0].y <= cfg_if.data;
        CFG_VEH_BX: veh_q[1].x <= cfg_if.data;
        CFG_VEH_BY: veh_q[1].y <= cfg_if.data;
        CFG_VEH_CX: veh_q[2].x <= cfg_if.data;
        CFG_VEH_CY: veh_q[2].y <= cfg_if.data;
        CFG_VEH_DX: veh_q[3].x <= cfg_if.data;
        CFG_VEH_DY: veh_q[3].y <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // hold only when an end marker cannot hand its result over
  assign adv = !(vld_q[LAST] && (cmd_q[LAST] == CMD_END) && out_valid_q && !out_if.ready);
  assign in_if.ready = adv;
  assign commit = adv && vld_q[LAST];

  always_comb begin
    obs_in[0].x = in_if.x_a;
    obs_in[0].y = in_if.y_a;
    obs_in[1].x = in_if.x_b;
    obs_in[1].y = in_if.y_b;
    obs_in[2].x = in_if.x_c;
    obs_in[2].y = in_if.y_c;
    obs_in[3].x = in_if.x_d;
    obs_in[3].y = in_if.y_d;
  end

  assign veh_ab = edge_of(veh_q[0], veh_q[1]);
  assign veh_bc = edge_of(veh_q[1], veh_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      for (int s = 0; s < LANE_STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (adv) begin
      vld1_q   <= in_if.valid;
      vld2_q   <= vld1_q;
      vld_q[0] <= vld2_q;
      for (int s = 1; s < LANE_STAGES; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cmd1_q     <= cmd_e'(in_if.cmd);
      obs1_q     <= obs_in;
      cmd2_q     <= cmd1_q;
      obs2_q     <= obs1_q;
      axis2_q[0] <= perp(veh_ab);
      axis2_q[1] <= perp(veh_bc);
      axis2_q[2] <= perp(edge_of(obs1_q[0], obs1_q[1]));
      axis2_q[3] <= perp(edge_of(obs1_q[1], obs1_q[2]));
      ab2_q      <= veh_ab;
      bc2_q      <= veh_bc;
      cmd_q[0]   <= cmd2_q;
      for (int s = 1; s < LANE_STAGES; s++) begin
        cmd_q[s] <= cmd_q[s-1];
      end
    end
  end

  // lanes
  for (genvar g = 0; g < N_AXES; g++) begin : g_axis
    always_comb begin
      lane_in[g].axis = axis2_q[g];
      lane_in[g].veh  = veh_q;
      lane_in[g].obs  = obs2_q;
    end

    rcc_axis_lane u_lane (
      .clk_i  (clk_i),
      .adv_i  (adv),
      .lane_i (lane_in[g]),
      .ovl_o  (lane_ovl[g])
    );
  end

  always_comb begin
    pt_in.pt  = obs2_q[0];
    pt_in.veh = veh_q;
    pt_in.ab  = ab2_q;
    pt_in.bc  = bc2_q;
  end

  rcc_point_lane u_point (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .lane_i   (pt_in),
    .inside_o (pt_inside)
  );

  // merge: every axis must overlap
  always_comb begin
    all_ovl = 1'b1;
    for (int a = 0; a < N_AXES; a++) begin
      all_ovl = all_ovl & lane_ovl[a];
    end
  end

  // frame state, applied in item order at the last stage
  always_comb begin
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    hit_d      = hit_q;
    slot_d     = slot_q;
    drop_d     = drop_q;
    coll_d     = coll_q;
    oidx_d     = oidx_q;
    ovf_d      = ovf_q;
    end_commit = 1'b0;
    if (commit) begin
      unique case (cmd_q[LAST])
        CMD_FOOT: begin
          if (cnt_q >= CNT_W'(MAX_OBS)) begin
            drop_d = 1'b1;
            cur_d  = 1'b0;
          end else begin
            cur_d = !hit_q && all_ovl;
            cnt_d = cnt_q + 1'b1;
          end
        end
        CMD_POINT: begin
          if (cur_q && !hit_q && pt_inside) begin
            hit_d  = 1'b1;
            slot_d = SLOT_W'(cnt_q - 1'b1);
          end
        end
        CMD_END: begin
          end_commit = 1'b1;
          coll_d     = hit_q;
          oidx_d     = hit_q ? IDX_W'(slot_q) : '1;
          ovf_d      = drop_q;
          cnt_d      = '0;
          cur_d      = 1'b0;
          hit_d      = 1'b0;
          slot_d     = '0;
          drop_d     = 1'b0;
        end
        CMD_RSVD: ;
      endcase
    end
  end

  always_comb begin
    if (end_commit) begin
      out_valid_d = 1'b1;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      cur_q       <= 1'b0;
      hit_q       <= 1'b0;
      slot_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      cur_q       <= cur_d;
      hit_q       <= hit_d;
      slot_q      <= slot_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    coll_q <= coll_d;
    oidx_q <= oidx_d;
    ovf_q  <= ovf_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.collision      = coll_q;
  assign out_if.obstacle_index = oidx_q;
  assign out_if.overflow       = ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_OBS))
    else $error("footprint count above capacity");

  a_slot_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> (CNT_W'(slot_q) < cnt_q))
    else $error("hit slot not among accepted footprints");

  a_end_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_commit |=> (out_valid_q && (cnt_q == '0) && !hit_q && !drop_q))
    else $error("end marker did not post result and clear frame");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> (out_valid_q && vld_q[LAST] && (cmd_q[LAST] == CMD_END)))
    else $error("pipeline held without a blocked result");

endmodule
